/* rtl/core/mbeq_pkg.sv */
package mbeq_pkg;

   localparam int NUM_BUTTONS = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int BATCH_SLOTS = NUM_BUTTONS + 1;
   localparam int FLAGS_WIDTH = 8;
   localparam int CODE_WIDTH  = 3;
   localparam int BTN_WIDTH   = 2;
   localparam int SEL_WIDTH   = 2;

   // button_flags bit positions of the double-click flags
   localparam int FLAG_L_DBL = 6;
   localparam int FLAG_R_DBL = 7;

   typedef enum logic [0:0] {
      CMD_REPORT = 1'b0,
      CMD_TICK   = 1'b1
   } cmd_type;

   typedef enum logic [CODE_WIDTH-1:0] {
      EV_L_DOWN = 3'd0,
      EV_L_UP   = 3'd1,
      EV_R_DOWN = 3'd2,
      EV_R_UP   = 3'd3,
      EV_M_DOWN = 3'd4,
      EV_M_UP   = 3'd5,
      EV_L_DBL  = 3'd6,
      EV_R_DBL  = 3'd7
   } event_type;

   // One queue slot or the pending double-click slot
   typedef struct packed {
      logic valid;
      logic up_or_right;
   } slot_type;

   // Work handed from the input register to the state tracker
   typedef struct packed {
      logic                   report;
      logic                   tick;
      logic [FLAGS_WIDTH-1:0] flags;
   } op_type;

   // Events released by one tick, slot 0 first
   typedef struct packed {
      logic [BATCH_SLOTS-1:0]                 valid;
      logic [BATCH_SLOTS-1:0][CODE_WIDTH-1:0] code;
   } batch_type;

endpackage

/* rtl/core/mbeq_req_if.sv */
interface mbeq_req_if;
   logic                            valid;
   logic                            ready;
   logic                            cmd;
   logic [mbeq_pkg::FLAGS_WIDTH-1:0] button_flags;

   modport source (output valid, output cmd, output button_flags, input ready);
   modport sink   (input valid, input cmd, input button_flags, output ready);
endinterface

/* rtl/core/mbeq_rsp_if.sv */
interface mbeq_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [mbeq_pkg::CODE_WIDTH-1:0] event_code;
   logic                            last;

   modport source (output valid, output event_code, output last, input ready);
   modport sink   (input valid, input event_code, input last, output ready);
endinterface

/* rtl/core/mbeq_tracker.sv */
// Button state, per-button event queues and the pending double-click slot
module mbeq_tracker (
   input  logic                clock,
   input  logic                reset,
   input  mbeq_pkg::op_type    op,
   output mbeq_pkg::batch_type tick_batch
);

   logic [mbeq_pkg::NUM_BUTTONS-1:0] down_ff, down_in;
   mbeq_pkg::slot_type [mbeq_pkg::NUM_BUTTONS-1:0][mbeq_pkg::QUEUE_DEPTH-1:0] queue_ff, queue_in;
   mbeq_pkg::slot_type pend_ff, pend_in;

   logic                           have;
   logic [mbeq_pkg::BTN_WIDTH-1:0] ev_btn;
   logic                           ev_up;

   // Events a tick would release from the current state
   always_comb begin
      tick_batch.valid[0] = pend_ff.valid;
      tick_batch.code[0]  = pend_ff.up_or_right ? mbeq_pkg::EV_R_DBL : mbeq_pkg::EV_L_DBL;
      for (int b = 0; b < mbeq_pkg::NUM_BUTTONS; b++) begin
         tick_batch.valid[b+1] = queue_ff[b][0].valid;
         tick_batch.code[b+1]  = {mbeq_pkg::BTN_WIDTH'(b), queue_ff[b][0].up_or_right};
      end
   end

   // Report: first changed button by priority, double-click override
   always_comb begin
      have    = 1'b0;
      ev_btn  = '0;
      ev_up   = 1'b0;
      down_in = down_ff;
      for (int b = 0; b < mbeq_pkg::NUM_BUTTONS; b++) begin
         if (!have) begin
            if (op.flags[2*b] && !down_ff[b]) begin
               down_in[b] = 1'b1;
               ev_btn     = mbeq_pkg::BTN_WIDTH'(b);
               ev_up      = 1'b0;
               have       = 1'b1;
            end else if (op.flags[2*b+1] && down_ff[b]) begin
               down_in[b] = 1'b0;
               ev_btn     = mbeq_pkg::BTN_WIDTH'(b);
               ev_up      = 1'b1;
               have       = 1'b1;
            end
         end
      end
      if (op.flags[mbeq_pkg::FLAG_R_DBL]) begin
         ev_btn = mbeq_pkg::BTN_WIDTH'(1);
         ev_up  = 1'b0;
         have   = 1'b1;
      end else if (op.flags[mbeq_pkg::FLAG_L_DBL]) begin
         ev_btn = '0;
         ev_up  = 1'b0;
         have   = 1'b1;
      end
   end

   // Next state for reports and ticks
   always_comb begin
      queue_in = queue_ff;
      pend_in  = pend_ff;
      if (op.tick) begin
         pend_in = '0;
         for (int b = 0; b < mbeq_pkg::NUM_BUTTONS; b++) begin
            if (queue_ff[b][0].valid) begin
               queue_in[b][0] = queue_ff[b][1];
               queue_in[b][1] = '0;
            end
         end
      end else if (op.report) begin
         if (op.flags[mbeq_pkg::FLAG_R_DBL]) begin
            pend_in = '{valid: 1'b1, up_or_right: 1'b1};
         end else if (op.flags[mbeq_pkg::FLAG_L_DBL]) begin
            pend_in = '{valid: 1'b1, up_or_right: 1'b0};
         end
         for (int b = 0; b < mbeq_pkg::NUM_BUTTONS; b++) begin
            if (have && ev_btn == mbeq_pkg::BTN_WIDTH'(b)) begin
               if (!queue_ff[b][0].valid) begin
                  queue_in[b][0] = '{valid: 1'b1, up_or_right: ev_up};
               end else if (!queue_ff[b][1].valid) begin
                  queue_in[b][1] = '{valid: 1'b1, up_or_right: ev_up};
               end else if (ev_up && !queue_ff[b][1].up_or_right) begin
                  // up meets a queued down: both cancel
                  queue_in[b][1] = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         down_ff  <= '0;
         queue_ff <= '0;
         pend_ff  <= '0;
      end else begin
         if (op.report) begin
            down_ff <= down_in;
         end
         queue_ff <= queue_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

/* rtl/core/mouse_button_event_queue.sv */
// Channel | Dir | Fields                    | Transfer
// req_bus | in  | cmd, button_flags         | valid && ready
// rsp_bus | out | event_code, last          | valid && ready
//
// An item enters an input register and is handled there. A report produces no
// result; reports flow one per cycle unless a tick holds the input register.
// A tick loads its 0 to 4 events into the result register, which sends one per
// cycle while rsp_bus.ready is high, so a tick holds the input register until
// the previous tick's last event is being transferred. Reset clears valid flags
// and tracker state. Reports keep flowing while results wait on rsp_bus.ready.
module mouse_button_event_queue (
   input logic        clock,
   input logic        reset,
   mbeq_req_if.sink   req_bus,
   mbeq_rsp_if.source rsp_bus
);

   logic                              req_valid, req_ready, req_cmd;
   logic [mbeq_pkg::FLAGS_WIDTH-1:0]  req_button_flags;
   logic                              rsp_valid, rsp_ready, rsp_last;
   logic [mbeq_pkg::CODE_WIDTH-1:0]   rsp_event_code;

   assign req_valid        = req_bus.valid;
   assign req_cmd          = req_bus.cmd;
   assign req_button_flags = req_bus.button_flags;
   assign req_bus.ready    = req_ready;
   assign rsp_ready        = rsp_bus.ready;
   assign rsp_bus.valid    = rsp_valid;
   assign rsp_bus.event_code = rsp_event_code;
   assign rsp_bus.last     = rsp_last;

   logic                             in_valid_ff;
   mbeq_pkg::cmd_type                in_cmd_ff;
   logic [mbeq_pkg::FLAGS_WIDTH-1:0] in_flags_ff;

   logic [mbeq_pkg::BATCH_SLOTS-1:0]                          out_valid_ff, out_valid_in;
   logic [mbeq_pkg::BATCH_SLOTS-1:0][mbeq_pkg::CODE_WIDTH-1:0] out_code_ff, out_code_in;

   mbeq_pkg::op_type    op;
   mbeq_pkg::batch_type tick_batch;

   logic                           rsp_fire, batch_free, consume;
   logic [mbeq_pkg::SEL_WIDTH-1:0] sel;

   // Result register: lowest valid slot goes out first
   always_comb begin
      sel = '0;
      for (int i = mbeq_pkg::BATCH_SLOTS - 1; i >= 0; i--) begin
         if (out_valid_ff[i]) begin
            sel = mbeq_pkg::SEL_WIDTH'(i);
         end
      end
   end

   assign rsp_valid      = |out_valid_ff;
   assign rsp_event_code = out_code_ff[sel];
   assign rsp_last       = (out_valid_ff & (out_valid_ff - 1'b1)) == '0;
   assign rsp_fire       = rsp_valid && rsp_ready;
   assign batch_free     = !rsp_valid || (rsp_fire && rsp_last);

   // Input register hands its item over when it can complete
   assign consume   = in_valid_ff && (in_cmd_ff == mbeq_pkg::CMD_REPORT || batch_free);
   assign req_ready = !in_valid_ff || consume;

   assign op.report = consume && in_cmd_ff == mbeq_pkg::CMD_REPORT;
   assign op.tick   = consume && in_cmd_ff == mbeq_pkg::CMD_TICK;
   assign op.flags  = in_flags_ff;

   mbeq_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .tick_batch (tick_batch)
   );

   // Result register next value
   always_comb begin
      out_valid_in = out_valid_ff;
      out_code_in  = out_code_ff;
      if (op.tick) begin
         out_valid_in = tick_batch.valid;
         out_code_in  = tick_batch.code;
      end else if (rsp_fire) begin
         out_valid_in[sel] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= '0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (consume) begin
            in_valid_ff <= 1'b0;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_cmd_ff   <= mbeq_pkg::cmd_type'(req_cmd);
         in_flags_ff <= req_button_flags;
      end
      out_code_ff <= out_code_in;
   end

endmodule

/* rtl/core/mbeq_checker.sv */
module mbeq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [mbeq_pkg::CODE_WIDTH-1:0] rsp_event_code,
   input logic                            rsp_last
);

   logic                           rsp_fire;
   logic [mbeq_pkg::SEL_WIDTH-1:0] count_ff;

   assign rsp_fire = rsp_valid && rsp_ready;

   // Transfers seen so far in the current tick's burst
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (rsp_fire) begin
         count_ff <= rsp_last ? '0 : count_ff + 1'b1;
      end
   end

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_code) && $stable(rsp_last))
      else $error("result changed while stalled");

   // Nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A burst carries at most four events
   a_burst_len: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && count_ff == 2'd3 |-> rsp_last)
      else $error("burst longer than four events");

   // Rest of a burst follows without a gap
   a_burst_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_last |=> rsp_valid)
      else $error("gap inside a burst");

endmodule

bind mouse_button_event_queue mbeq_checker u_mbeq_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_event_code (rsp_event_code),
   .rsp_last       (rsp_last)
);
